@@ sv/bitmap_font_file_validator_assert.svh @@
// assertion macros for the bitmap font file validator checker
// expects signals clk and rst_n in the scope where a macro is used
`ifndef BITMAP_FONT_FILE_VALIDATOR_ASSERT_SVH
`define BITMAP_FONT_FILE_VALIDATOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BFV_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bitmap font validator check failed");

// next-cycle implication, checked outside reset
`define BFV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bitmap font validator check failed");

`endif

@@ sv/bfv_pkg.sv @@
// shared types and constants for the bitmap font file validator
// no dependencies; used by bfv_parser and bitmap_font_file_validator
package bfv_pkg;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_RECORDS = 2'd1,
        PH_TRAIL   = 2'd2,
        PH_FAILED  = 2'd3
    } phase_t;

    typedef struct packed {
        logic        valid_res;
        logic [15:0] glyph_count;
        logic [31:0] file_bytes;
        logic [3:0]  format_version;
    } res_t;

    // header word numbers, counted from 1 at the word's last byte
    localparam logic [2:0] HW_COUNT   = 3'd1;
    localparam logic [2:0] HW_VERSION = 3'd2;
    localparam logic [2:0] HW_SIZE    = 3'd3;
    localparam logic [2:0] HW_ASCENT  = 3'd5;
    localparam logic [2:0] HW_DESCENT = 3'd6;

    // legacy record word numbers
    localparam logic [2:0] LW_CODEPOINT = 3'd1;
    localparam logic [2:0] LW_HEIGHT    = 3'd2;
    localparam logic [2:0] LW_WIDTH     = 3'd3;
    localparam logic [2:0] LW_ADVANCE   = 3'd4;

    // compact record byte positions
    localparam logic [4:0] CP_CODEPOINT = 5'd2;
    localparam logic [4:0] CP_HEIGHT    = 5'd3;
    localparam logic [4:0] CP_WIDTH     = 5'd4;
    localparam logic [4:0] CP_ADVANCE   = 5'd5;

    localparam logic [4:0] LEGACY_REC_LEN  = 5'd28;
    localparam logic [4:0] COMPACT_REC_LEN = 5'd7;
    localparam logic [31:0] HEADER_BYTES   = 32'd24;

    localparam logic [3:0] VER_LEGACY  = 4'd11;
    localparam logic [3:0] VER_COMPACT = 4'd12;

    localparam logic [31:0] FONT_SIZE_MIN = 32'd8;
    localparam logic [31:0] FONT_SIZE_MAX = 32'd48;
    localparam logic [31:0] ASCENT_MAX    = 32'd64;
    localparam logic [31:0] DESCENT_MAX   = 32'd32;
    localparam logic [31:0] DIM_MAX       = 32'd64;
    localparam logic [31:0] ADVANCE_MAX   = 32'd96;

    localparam logic [15:0] MAX_GLYPHS_RESET = 16'd512;

endpackage

@@ sv/bfv_parser.sv @@
// per-byte header and glyph record parser with running length bookkeeping
// depends on bfv_pkg; instantiated by bitmap_font_file_validator
module bfv_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    input  logic [15:0]        max_glyphs,
    output bfv_pkg::res_t      res
);

    bfv_pkg::phase_t phase_reg, phase_next;
    logic [31:0] byte_total_reg, byte_total_next;
    logic [31:0] word_shift_reg, word_shift_next;
    logic [4:0]  field_pos_reg, field_pos_next;
    logic [15:0] header_glyphs_reg, header_glyphs_next;
    logic        compact_reg, compact_next;
    logic [15:0] glyphs_done_reg, glyphs_done_next;
    logic [15:0] prev_cp_reg, prev_cp_next;
    logic [31:0] need_reg, need_next;
    logic [6:0]  glyph_height_reg, glyph_height_next;
    logic [6:0]  glyph_width_reg, glyph_width_next;
    logic [12:0] area_reg;

    logic [31:0] word;
    logic [31:0] byte_ext;
    logic [4:0]  pos_inc;
    logic        word_end;
    logic [2:0]  word_idx;
    logic        fail;
    logic        cp_high;
    logic [15:0] cp_val;
    logic        cp_check;
    logic [18:0] glyphs_x7;
    logic [20:0] rec_bytes;
    logic [4:0]  rec_len;
    logic [15:0] done_inc;

    always_comb
    begin
        byte_total_next    = (&byte_total_reg) ? byte_total_reg : byte_total_reg + 32'd1;
        word_shift_next    = word_shift_reg;
        field_pos_next     = field_pos_reg;
        phase_next         = phase_reg;
        header_glyphs_next = header_glyphs_reg;
        compact_next       = compact_reg;
        glyphs_done_next   = glyphs_done_reg;
        prev_cp_next       = prev_cp_reg;
        need_next          = need_reg;
        glyph_height_next  = glyph_height_reg;
        glyph_width_next   = glyph_width_reg;

        word      = {word_shift_reg[23:0], data_byte};
        byte_ext  = {24'd0, data_byte};
        pos_inc   = field_pos_reg + 5'd1;
        word_end  = (pos_inc[1:0] == 2'd0);
        word_idx  = pos_inc[4:2];
        fail      = 1'b0;
        cp_high   = 1'b0;
        cp_val    = word[15:0];
        cp_check  = 1'b0;
        glyphs_x7 = ({3'd0, header_glyphs_reg} << 3) - {3'd0, header_glyphs_reg};
        rec_bytes = 21'd0;
        rec_len   = compact_reg ? bfv_pkg::COMPACT_REC_LEN : bfv_pkg::LEGACY_REC_LEN;
        done_inc  = glyphs_done_reg + 16'd1;

        if (phase_reg == bfv_pkg::PH_HEADER)
        begin
            word_shift_next = word;
            field_pos_next  = pos_inc;
            if (word_end)
            begin
                case (word_idx)
                    bfv_pkg::HW_COUNT:
                    begin
                        if (word == 32'd0 || word > {16'd0, max_glyphs})
                            fail = 1'b1;
                        else
                            header_glyphs_next = word[15:0];
                    end
                    bfv_pkg::HW_VERSION:
                    begin
                        if (word == {28'd0, bfv_pkg::VER_COMPACT})
                        begin
                            compact_next = 1'b1;
                            rec_bytes    = {2'd0, glyphs_x7};
                        end
                        else if (word == {28'd0, bfv_pkg::VER_LEGACY})
                        begin
                            compact_next = 1'b0;
                            rec_bytes    = {glyphs_x7, 2'b00};
                        end
                        else
                            fail = 1'b1;
                        // fixed part of the required length, bitmaps added per glyph
                        need_next = bfv_pkg::HEADER_BYTES + {11'd0, rec_bytes};
                    end
                    bfv_pkg::HW_SIZE:
                    begin
                        if (word < bfv_pkg::FONT_SIZE_MIN || word > bfv_pkg::FONT_SIZE_MAX)
                            fail = 1'b1;
                    end
                    bfv_pkg::HW_ASCENT:
                    begin
                        if (word > bfv_pkg::ASCENT_MAX)
                            fail = 1'b1;
                    end
                    bfv_pkg::HW_DESCENT:
                    begin
                        if (word > bfv_pkg::DESCENT_MAX)
                            fail = 1'b1;
                        else
                        begin
                            phase_next     = bfv_pkg::PH_RECORDS;
                            field_pos_next = 5'd0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        else if (phase_reg == bfv_pkg::PH_RECORDS)
        begin
            word_shift_next = word;
            field_pos_next  = pos_inc;
            if (compact_reg)
            begin
                case (pos_inc)
                    bfv_pkg::CP_CODEPOINT:
                    begin
                        cp_check = 1'b1;
                        cp_val   = word[15:0];
                    end
                    bfv_pkg::CP_HEIGHT:
                    begin
                        if (byte_ext > bfv_pkg::DIM_MAX)
                            fail = 1'b1;
                        else
                            glyph_height_next = data_byte[6:0];
                    end
                    bfv_pkg::CP_WIDTH:
                    begin
                        if (byte_ext > bfv_pkg::DIM_MAX)
                            fail = 1'b1;
                        else
                            glyph_width_next = data_byte[6:0];
                    end
                    bfv_pkg::CP_ADVANCE:
                    begin
                        if (byte_ext > bfv_pkg::ADVANCE_MAX)
                            fail = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (word_end)
            begin
                case (word_idx)
                    bfv_pkg::LW_CODEPOINT:
                    begin
                        cp_check = 1'b1;
                        cp_high  = |word[31:16];
                        cp_val   = word[15:0];
                    end
                    bfv_pkg::LW_HEIGHT:
                    begin
                        if (word > bfv_pkg::DIM_MAX)
                            fail = 1'b1;
                        else
                            glyph_height_next = word[6:0];
                    end
                    bfv_pkg::LW_WIDTH:
                    begin
                        if (word > bfv_pkg::DIM_MAX)
                            fail = 1'b1;
                        else
                            glyph_width_next = word[6:0];
                    end
                    bfv_pkg::LW_ADVANCE:
                    begin
                        if (word > bfv_pkg::ADVANCE_MAX)
                            fail = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end

            // codepoints must rise strictly from the second glyph on
            if (cp_check)
            begin
                if (cp_high || (glyphs_done_reg != 16'd0 && cp_val <= prev_cp_reg))
                    fail = 1'b1;
                else
                    prev_cp_next = cp_val;
            end

            if (!fail && pos_inc == rec_len)
            begin
                need_next        = need_reg + {19'd0, area_reg};
                glyphs_done_next = done_inc;
                field_pos_next   = 5'd0;
                if (done_inc == header_glyphs_reg)
                    phase_next = bfv_pkg::PH_TRAIL;
            end
        end

        if (fail)
            phase_next = bfv_pkg::PH_FAILED;

        res.valid_res      = (phase_next == bfv_pkg::PH_TRAIL) && (byte_total_next >= need_next);
        res.glyph_count    = res.valid_res ? header_glyphs_next : 16'd0;
        res.file_bytes     = byte_total_next;
        res.format_version = !res.valid_res ? 4'd0 :
                             (compact_next ? bfv_pkg::VER_COMPACT : bfv_pkg::VER_LEGACY);

        // end of file: start over for the next one
        if (last_byte)
        begin
            phase_next         = bfv_pkg::PH_HEADER;
            byte_total_next    = 32'd0;
            word_shift_next    = 32'd0;
            field_pos_next     = 5'd0;
            header_glyphs_next = 16'd0;
            compact_next       = 1'b0;
            glyphs_done_next   = 16'd0;
            prev_cp_next       = 16'd0;
            need_next          = 32'd0;
            glyph_height_next  = 7'd0;
            glyph_width_next   = 7'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= bfv_pkg::PH_HEADER;
            byte_total_reg    <= 32'd0;
            word_shift_reg    <= 32'd0;
            field_pos_reg     <= 5'd0;
            header_glyphs_reg <= 16'd0;
            compact_reg       <= 1'b0;
            glyphs_done_reg   <= 16'd0;
            prev_cp_reg       <= 16'd0;
            need_reg          <= 32'd0;
            glyph_height_reg  <= 7'd0;
            glyph_width_reg   <= 7'd0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            byte_total_reg    <= byte_total_next;
            word_shift_reg    <= word_shift_next;
            field_pos_reg     <= field_pos_next;
            header_glyphs_reg <= header_glyphs_next;
            compact_reg       <= compact_next;
            glyphs_done_reg   <= glyphs_done_next;
            prev_cp_reg       <= prev_cp_next;
            need_reg          <= need_next;
            glyph_height_reg  <= glyph_height_next;
            glyph_width_reg   <= glyph_width_next;
        end
    end

    // bitmap area of the current glyph, ready well before the record ends
    always_ff @(posedge clk)
    begin
        area_reg <= {6'd0, glyph_height_reg} * {6'd0, glyph_width_reg};
    end

endmodule

@@ sv/bitmap_font_file_validator.sv @@
// top level of the bitmap font file validator: handshake, config register, result register
// depends on bfv_pkg and bfv_parser
//
// Checks a bitmap font file streamed in one byte per beat, big-endian, with
// last_byte marking the final byte. A 24-byte header (glyph count, version 11 or
// 12, font size, ascent, descent) is checked against fixed limits and against
// max_glyphs, then one metric record per glyph (28 bytes for version 11, 7 for
// version 12). The file passes when every check holds and it is at least as long
// as header, records and the width*height bitmap bytes together; trailing bytes
// are fine. After the first failed check the remaining bytes are only counted.
// Exactly one result beat comes out per file, for its last byte. Each byte is
// parsed by the parser state registers and the result goes into an output
// register, so with out_ready high a byte is taken every clock, also in the
// cycle a result leaves. While a result waits for out_ready no byte is taken.
// The result appears in the cycle after the last byte is taken. max_glyphs
// (cfg_we/cfg_wdata) resets to 512 and should only be written between files.
module bitmap_font_file_validator (
    input  logic        clk,
    input  logic        rst_n,
    // input byte channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic        valid_res,
    output logic [15:0] glyph_count,
    output logic [31:0] file_bytes,
    output logic [3:0]  format_version,
    // max_glyphs register write
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    logic [15:0]   max_glyphs_reg;
    logic          out_valid_reg;
    bfv_pkg::res_t res_reg;
    bfv_pkg::res_t res_now;
    logic          step;

    // a byte may enter whenever the result register is free or being drained
    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    bfv_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .max_glyphs (max_glyphs_reg),
        .res        (res_now)
    );

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_glyphs_reg <= bfv_pkg::MAX_GLYPHS_RESET;
        else if (cfg_we)
            max_glyphs_reg <= cfg_wdata;
    end

    // result beat valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step && last_byte)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // result payload, loaded only on the final byte of a file
    always_ff @(posedge clk)
    begin
        if (step && last_byte)
            res_reg <= res_now;
    end

    assign out_valid      = out_valid_reg;
    assign valid_res      = res_reg.valid_res;
    assign glyph_count    = res_reg.glyph_count;
    assign file_bytes     = res_reg.file_bytes;
    assign format_version = res_reg.format_version;

endmodule

@@ sv/bfv_checker.sv @@
// port-level checks for the bitmap font file validator, bound to the top level
// depends on bitmap_font_file_validator_assert.svh and bfv_pkg
`include "bitmap_font_file_validator_assert.svh"

module bfv_port_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        last_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        valid_res,
    input  logic [15:0] glyph_count,
    input  logic [31:0] file_bytes,
    input  logic [3:0]  format_version
);

    logic [52:0] out_beat;
    logic        known_version;
    logic        min_size;

    assign out_beat      = {valid_res, glyph_count, file_bytes, format_version};
    assign known_version = (format_version == bfv_pkg::VER_LEGACY)
                           || (format_version == bfv_pkg::VER_COMPACT);
    // header plus one compact record
    assign min_size      = file_bytes >= bfv_pkg::HEADER_BYTES
                                         + {27'd0, bfv_pkg::COMPACT_REC_LEN};

    // stalled result beat holds
    `BFV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_beat))
    // final byte always yields a result beat
    `BFV_ASSERT_NEXT(a_last_gives_result, in_valid && in_ready && last_byte, out_valid)
    // rejected files carry no count and no version
    `BFV_ASSERT_NOW(a_reject_zeroed, out_valid && !valid_res, glyph_count == 16'd0 && format_version == 4'd0)
    // accepted files name a known version
    `BFV_ASSERT_NOW(a_accept_version, out_valid && valid_res, known_version)
    // accepted file holds at least a header and one compact record
    `BFV_ASSERT_NOW(a_accept_size, out_valid && valid_res, glyph_count != 16'd0 && min_size)

endmodule

bind bitmap_font_file_validator bfv_port_checker u_bfv_checker (.*);

@@ bench/bfv_checker.sv @@
`timescale 1ns / 1ps
// checker for the bitmap font file validator: watches the byte and result channels
// and the max_glyphs writes, predicts one result per file and compares it field by field
// depends on bfv_pkg
module bfv_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        valid_res,
    input  logic [15:0] glyph_count,
    input  logic [31:0] file_bytes,
    input  logic [3:0]  format_version,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    output int          mismatches,
    output int          pending,
    output int          results,
    output int          passed
);

    // predicted parser state
    bfv_pkg::phase_t phase;
    logic [31:0] byte_cnt;
    logic [31:0] shift_word;
    logic [4:0]  field_pos;
    logic [15:0] hdr_glyphs;
    logic        compact;
    logic [15:0] glyphs_seen;
    logic [15:0] last_cp;
    logic [31:0] bitmap_bytes;
    logic [6:0]  cur_h;
    logic [6:0]  cur_w;
    logic        failed;
    logic [15:0] glyph_limit;

    bfv_pkg::res_t verdict_q[$];
    bfv_pkg::res_t got;
    bfv_pkg::res_t want;
    int          errs = 0;
    int          n_results = 0;
    int          n_passed = 0;

    task automatic restart_file();
        phase        = bfv_pkg::PH_HEADER;
        byte_cnt     = '0;
        shift_word   = '0;
        field_pos    = '0;
        hdr_glyphs   = '0;
        compact      = 1'b0;
        glyphs_seen  = '0;
        last_cp      = '0;
        bitmap_bytes = '0;
        cur_h        = '0;
        cur_w        = '0;
        failed       = 1'b0;
    endtask

    task automatic reject_file();
        phase  = bfv_pkg::PH_FAILED;
        failed = 1'b1;
    endtask

    task automatic check_codepoint(input logic [31:0] cp);
        if (cp > 32'hffff || (glyphs_seen != 0 && cp[15:0] <= last_cp))
            reject_file();
        else
            last_cp = cp[15:0];
    endtask

    task automatic check_height(input logic [31:0] v);
        if (v > bfv_pkg::DIM_MAX)
            reject_file();
        else
            cur_h = v[6:0];
    endtask

    task automatic check_width(input logic [31:0] v);
        if (v > bfv_pkg::DIM_MAX)
            reject_file();
        else
            cur_w = v[6:0];
    endtask

    task automatic check_advance(input logic [31:0] v);
        if (v > bfv_pkg::ADVANCE_MAX)
            reject_file();
    endtask

    // one accepted byte; a final byte queues the file verdict and starts over
    task automatic parse_font_byte(input logic [7:0] b, input logic fin);
        logic [4:0]    rec_len;
        logic [31:0]   need;
        bfv_pkg::res_t r;
        rec_len = compact ? bfv_pkg::COMPACT_REC_LEN : bfv_pkg::LEGACY_REC_LEN;
        if (byte_cnt != '1)
            byte_cnt++;
        if (phase == bfv_pkg::PH_HEADER || phase == bfv_pkg::PH_RECORDS)
            shift_word = {shift_word[23:0], b};
        if (phase == bfv_pkg::PH_HEADER)
        begin
            field_pos++;
            if (field_pos[1:0] == 2'd0)
            begin
                case (field_pos[4:2])
                    bfv_pkg::HW_COUNT:
                        if (shift_word == 0 || shift_word > {16'd0, glyph_limit})
                            reject_file();
                        else
                            hdr_glyphs = shift_word[15:0];
                    bfv_pkg::HW_VERSION:
                        if (shift_word == 32'(bfv_pkg::VER_COMPACT))
                            compact = 1'b1;
                        else if (shift_word == 32'(bfv_pkg::VER_LEGACY))
                            compact = 1'b0;
                        else
                            reject_file();
                    bfv_pkg::HW_SIZE:
                        if (shift_word < bfv_pkg::FONT_SIZE_MIN
                            || shift_word > bfv_pkg::FONT_SIZE_MAX)
                            reject_file();
                    bfv_pkg::HW_ASCENT:
                        if (shift_word > bfv_pkg::ASCENT_MAX)
                            reject_file();
                    bfv_pkg::HW_DESCENT:
                        if (shift_word > bfv_pkg::DESCENT_MAX)
                            reject_file();
                        else
                        begin
                            phase     = bfv_pkg::PH_RECORDS;
                            field_pos = '0;
                        end
                    default: ;
                endcase
            end
        end
        else if (phase == bfv_pkg::PH_RECORDS)
        begin
            field_pos++;
            if (compact)
            begin
                case (field_pos)
                    bfv_pkg::CP_CODEPOINT: check_codepoint({16'd0, shift_word[15:0]});
                    bfv_pkg::CP_HEIGHT:    check_height({24'd0, b});
                    bfv_pkg::CP_WIDTH:     check_width({24'd0, b});
                    bfv_pkg::CP_ADVANCE:   check_advance({24'd0, b});
                    default: ;
                endcase
            end
            else if (field_pos[1:0] == 2'd0)
            begin
                case (field_pos[4:2])
                    bfv_pkg::LW_CODEPOINT: check_codepoint(shift_word);
                    bfv_pkg::LW_HEIGHT:    check_height(shift_word);
                    bfv_pkg::LW_WIDTH:     check_width(shift_word);
                    bfv_pkg::LW_ADVANCE:   check_advance(shift_word);
                    default: ;
                endcase
            end
            if (phase != bfv_pkg::PH_FAILED && field_pos == rec_len)
            begin
                bitmap_bytes = bitmap_bytes + 32'(cur_w) * 32'(cur_h);
                glyphs_seen++;
                field_pos = '0;
                if (glyphs_seen == hdr_glyphs)
                    phase = bfv_pkg::PH_TRAIL;
            end
        end
        if (fin)
        begin
            r            = '0;
            r.file_bytes = byte_cnt;
            need = bfv_pkg::HEADER_BYTES + 32'(hdr_glyphs) * 32'(rec_len) + bitmap_bytes;
            if (phase == bfv_pkg::PH_TRAIL && !failed && byte_cnt >= need)
            begin
                r.valid_res      = 1'b1;
                r.glyph_count    = hdr_glyphs;
                r.format_version = compact ? bfv_pkg::VER_COMPACT : bfv_pkg::VER_LEGACY;
            end
            verdict_q.push_back(r);
            restart_file();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_file();
            glyph_limit = bfv_pkg::MAX_GLYPHS_RESET;
            verdict_q.delete();
        end
        else
        begin
            if (cfg_we)
                glyph_limit = cfg_wdata;
            if (out_valid && out_ready)
            begin
                got = {valid_res, glyph_count, file_bytes, format_version};
                if (verdict_q.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                        $display("result beat with no file pending:",
                                 " valid=%0d glyphs=%0d bytes=%0d ver=%0d",
                                 got.valid_res, got.glyph_count, got.file_bytes,
                                 got.format_version);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    n_results++;
                    if (want.valid_res)
                        n_passed++;
                    if (got.valid_res !== want.valid_res
                        || got.glyph_count !== want.glyph_count
                        || got.file_bytes !== want.file_bytes
                        || got.format_version !== want.format_version)
                    begin
                        errs++;
                        if (errs <= 10)
                            $display("file %0d: expected valid=%0d glyphs=%0d bytes=%0d ver=%0d,",
                                     n_results, want.valid_res, want.glyph_count,
                                     want.file_bytes, want.format_version,
                                     " got valid=%0d glyphs=%0d bytes=%0d ver=%0d",
                                     got.valid_res, got.glyph_count, got.file_bytes,
                                     got.format_version);
                    end
                end
            end
            if (in_valid && in_ready)
                parse_font_byte(data_byte, last_byte);
        end
        mismatches <= errs;
        pending    <= verdict_q.size();
        results    <= n_results;
        passed     <= n_passed;
    end

endmodule

@@ bench/bitmap_font_file_validator_tb.sv @@
`timescale 1ns / 1ps
// top of the bitmap font file validator bench: clock, reset, font file stimulus and verdict
// depends on bfv_pkg, bitmap_font_file_validator and bfv_checker
module bitmap_font_file_validator_tb;

    // version words as they stand in a file header
    localparam logic [31:0] FMT_LEGACY  = 32'(bfv_pkg::VER_LEGACY);
    localparam logic [31:0] FMT_COMPACT = 32'(bfv_pkg::VER_COMPACT);

    typedef struct packed {
        logic [31:0] cp;
        logic [31:0] h;
        logic [31:0] w;
        logic [31:0] adv;
    } glyph_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  data_byte = '0;
    logic        last_byte = 1'b0;
    logic        out_ready = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        in_ready;
    logic        out_valid;
    logic        valid_res;
    logic [15:0] glyph_count;
    logic [31:0] file_bytes;
    logic [3:0]  format_version;

    int mismatches;
    int pending;
    int results;
    int passed;

    glyph_t      glyphs[$];
    logic [7:0]  font_q[$];
    logic [15:0] max_glyphs_set = bfv_pkg::MAX_GLYPHS_RESET;
    int          burst_left = 0;
    int          bytes_sent = 0;
    int          files_sent = 0;
    int          settings_used = 1;
    int          stall_mode = 0;
    int          stall_left = 0;

    always #5 clk = ~clk;

    bitmap_font_file_validator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .valid_res      (valid_res),
        .glyph_count    (glyph_count),
        .file_bytes     (file_bytes),
        .format_version (format_version),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata)
    );

    // prediction and comparison live in the checker; the top only counts on its totals
    bfv_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .valid_res      (valid_res),
        .glyph_count    (glyph_count),
        .file_bytes     (file_bytes),
        .format_version (format_version),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .mismatches     (mismatches),
        .pending        (pending),
        .results        (results),
        .passed         (passed)
    );

    // result side stalls on its own pattern: open, coin toss, mostly closed, or ready at stall_left % 3 == 0
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 80);
        end
        stall_left--;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= ($urandom_range(0, 4) == 0);
            default: out_ready <= (stall_left % 3 == 0);
        endcase
    end

    // mostly inside [lo, hi] with the endpoints favored, now and then just outside
    function automatic logic [31:0] near_limits(input logic [31:0] lo, input logic [31:0] hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return (lo != 0 && r < 1) ? lo - 1 : hi + 1 + $urandom_range(0, 2);
        else if (r < 20)
            return r[0] ? lo : hi;
        else
            return $urandom_range(lo, hi);
    endfunction

    task automatic add_glyph(input logic [31:0] cp, input logic [31:0] h, input logic [31:0] w,
                             input logic [31:0] adv);
        glyph_t g;
        g.cp  = cp;
        g.h   = h;
        g.w   = w;
        g.adv = adv;
        glyphs.push_back(g);
    endtask

    task automatic push_word(input logic [31:0] w);
        font_q.push_back(w[31:24]);
        font_q.push_back(w[23:16]);
        font_q.push_back(w[15:8]);
        font_q.push_back(w[7:0]);
    endtask

    // header, one record per queued glyph, width*height bitmap bytes, then extra bytes
    task automatic build_font(input logic [31:0] count, input logic [31:0] ver,
                              input logic [31:0] size, input logic [31:0] asc,
                              input logic [31:0] desc, input int extra);
        int bm;
        font_q.delete();
        push_word(count);
        push_word(ver);
        push_word(size);
        push_word($urandom);
        push_word(asc);
        push_word(desc);
        bm = 0;
        foreach (glyphs[i])
        begin
            if (ver == FMT_COMPACT)
            begin
                font_q.push_back(glyphs[i].cp[15:8]);
                font_q.push_back(glyphs[i].cp[7:0]);
                font_q.push_back(glyphs[i].h[7:0]);
                font_q.push_back(glyphs[i].w[7:0]);
                font_q.push_back(glyphs[i].adv[7:0]);
                font_q.push_back(8'($urandom));
                font_q.push_back(8'($urandom));
            end
            else
            begin
                push_word(glyphs[i].cp);
                push_word(glyphs[i].h);
                push_word(glyphs[i].w);
                push_word(glyphs[i].adv);
                push_word($urandom);
                push_word($urandom);
                push_word($urandom);
            end
            if (glyphs[i].h <= bfv_pkg::DIM_MAX && glyphs[i].w <= bfv_pkg::DIM_MAX)
                bm += glyphs[i].h * glyphs[i].w;
        end
        repeat (bm + extra)
            font_q.push_back(8'($urandom));
    endtask

    // one beat; bursts of random length with a random gap before each burst.
    // every call drives in_valid in the step it is entered, so an accepted
    // beat is never repeated
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= fin;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // sends the file, or only its first cut bytes, with the last one marked
    task automatic send_font(input int cut);
        int len;
        len = (cut == 0 || cut > font_q.size()) ? font_q.size() : cut;
        for (int i = 0; i < len; i++)
            send_byte(font_q[i], i == len - 1);
        bytes_sent += len;
        files_sent++;
    endtask

    task automatic run_font(input logic [31:0] count, input logic [31:0] ver,
                            input logic [31:0] size, input logic [31:0] asc,
                            input logic [31:0] desc, input int extra, input int cut);
        build_font(count, ver, size, asc, desc, extra);
        send_font(cut);
        glyphs.delete();
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // register writes only with the block idle and every verdict in
    task automatic set_max_glyphs(input logic [15:0] v);
        in_valid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        max_glyphs_set = v;
        settings_used++;
    endtask

    // noise, or a well-formed font with random content, edge values and the odd corruption
    task automatic random_font();
        logic [31:0] count;
        logic [31:0] ver;
        logic [31:0] cp;
        logic [31:0] h;
        logic [31:0] w;
        int          r;
        int          n;
        int          cap;
        int          extra;
        int          cut;
        glyphs.delete();
        if ($urandom_range(0, 99) < 12)
        begin
            font_q.delete();
            repeat ($urandom_range(1, 40))
                font_q.push_back(8'($urandom));
            send_font(0);
            return;
        end
        cap   = (max_glyphs_set < 3) ? max_glyphs_set : 3;
        count = near_limits(1, cap);
        r     = $urandom_range(0, 99);
        ver   = (r < 3) ? $urandom_range(0, 15) : (r < 35) ? FMT_LEGACY : FMT_COMPACT;
        n     = (count == 0) ? 1 : (count > 6) ? 6 : count;
        cp    = $urandom_range(0, 16'hfe00);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            // repeated or falling codepoints now and then
            if (i > 0)
                cp = (r < 2) ? cp : (r < 4) ? cp - 1 : cp + $urandom_range(1, 60);
            h = $urandom_range(0, 4);
            w = $urandom_range(0, 4);
            if ($urandom_range(0, 7) == 0)
            begin
                if ($urandom_range(0, 1))
                    h = near_limits(0, bfv_pkg::DIM_MAX);
                else
                    w = near_limits(0, bfv_pkg::DIM_MAX);
            end
            add_glyph((r >= 98) ? (cp | 32'h10000) : cp, h, w,
                      near_limits(0, bfv_pkg::ADVANCE_MAX));
        end
        extra = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 4) : 0;
        build_font(count, ver, near_limits(bfv_pkg::FONT_SIZE_MIN, bfv_pkg::FONT_SIZE_MAX),
                   near_limits(0, bfv_pkg::ASCENT_MAX), near_limits(0, bfv_pkg::DESCENT_MAX),
                   extra);
        if ($urandom_range(0, 19) == 0)
            font_q[$urandom_range(0, font_q.size() - 1)] = 8'($urandom);
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, font_q.size()) : 0;
        send_font(cut);
    endtask

    task automatic random_segment(input int byte_goal);
        int bytes0;
        bytes0 = bytes_sent;
        while (bytes_sent - bytes0 < byte_goal)
        begin
            // now and then hold the sender until every verdict is back
            if ($urandom_range(0, 11) == 0)
            begin
                in_valid <= 1'b0;
                wait_drained();
            end
            random_font();
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // well-formed files, exact length and with trailing bytes
        add_glyph(32'h41, 2, 3, 4);
        run_font(1, FMT_COMPACT, 16, 10, 3, 0, 0);
        add_glyph(32'h20, 1, 1, 2);
        add_glyph(32'h21, 2, 2, 3);
        run_font(2, FMT_LEGACY, 16, 10, 3, 3, 0);

        // header and record fields at their legal limits
        add_glyph(32'h0, 0, 0, 0);
        add_glyph(32'hffff, bfv_pkg::DIM_MAX, 1, bfv_pkg::ADVANCE_MAX);
        run_font(2, FMT_COMPACT, bfv_pkg::FONT_SIZE_MIN, bfv_pkg::ASCENT_MAX,
                 bfv_pkg::DESCENT_MAX, 0, 0);
        add_glyph(32'hffff, 1, bfv_pkg::DIM_MAX, 0);
        run_font(1, FMT_LEGACY, bfv_pkg::FONT_SIZE_MAX, 0, 0, 0, 0);

        // bad version, zero glyph count; the bad version file keeps going so the
        // bytes after the failure are still counted
        add_glyph(32'h1, 1, 1, 1);
        run_font(1, FMT_LEGACY - 1, 16, 10, 3, 20, 0);
        add_glyph(32'h1, 1, 1, 1);
        run_font(1, FMT_COMPACT + 1, 16, 10, 3, 0, 0);
        add_glyph(32'h1, 1, 1, 1);
        run_font(0, FMT_COMPACT, 16, 10, 3, 0, 0);

        // header limits just crossed
        add_glyph(32'h1, 1, 1, 1);
        run_font(1, FMT_COMPACT, bfv_pkg::FONT_SIZE_MIN - 1, 10, 3, 0, 0);
        add_glyph(32'h1, 1, 1, 1);
        run_font(1, FMT_LEGACY, bfv_pkg::FONT_SIZE_MAX + 1, 10, 3, 0, 0);
        add_glyph(32'h1, 1, 1, 1);
        run_font(1, FMT_COMPACT, 16, bfv_pkg::ASCENT_MAX + 1, 3, 0, 0);
        add_glyph(32'h1, 1, 1, 1);
        run_font(1, FMT_LEGACY, 16, 10, bfv_pkg::DESCENT_MAX + 1, 0, 0);

        // codepoint too wide, repeated, falling
        add_glyph(32'h10000, 1, 1, 1);
        run_font(1, FMT_LEGACY, 16, 10, 3, 0, 0);
        add_glyph(32'h5, 1, 1, 1);
        add_glyph(32'h5, 1, 1, 1);
        run_font(2, FMT_COMPACT, 16, 10, 3, 0, 0);
        add_glyph(32'h9, 1, 1, 1);
        add_glyph(32'h8, 1, 1, 1);
        run_font(2, FMT_LEGACY, 16, 10, 3, 0, 0);

        // glyph metrics just over the limit, and a legacy word too wide for a byte
        add_glyph(32'h30, bfv_pkg::DIM_MAX + 1, 1, 1);
        run_font(1, FMT_COMPACT, 16, 10, 3, 0, 0);
        add_glyph(32'h30, 1, bfv_pkg::DIM_MAX + 1, 1);
        run_font(1, FMT_LEGACY, 16, 10, 3, 0, 0);
        add_glyph(32'h30, 1, 1, bfv_pkg::ADVANCE_MAX + 1);
        run_font(1, FMT_COMPACT, 16, 10, 3, 0, 0);
        add_glyph(32'h30, 32'h100, 1, 1);
        run_font(1, FMT_LEGACY, 16, 10, 3, 0, 0);

        // early end inside the header, the records, and one byte short of the bitmap
        add_glyph(32'h1, 1, 1, 1);
        run_font(1, FMT_COMPACT, 16, 10, 3, 0, 5);
        add_glyph(32'h1, 1, 1, 1);
        run_font(1, FMT_LEGACY, 16, 10, 3, 0, 34);
        add_glyph(32'h1, 4, 4, 1);
        run_font(1, FMT_COMPACT, 16, 10, 3, 0, 46);
        add_glyph(32'h1, bfv_pkg::DIM_MAX, bfv_pkg::DIM_MAX, 1);
        run_font(1, FMT_COMPACT, 16, 10, 3, 0, 131);
        // a file of one byte
        run_font(1, FMT_COMPACT, 16, 10, 3, 0, 1);

        // glyph count against max_glyphs at its extremes, zero included
        set_max_glyphs(1);
        add_glyph(32'h7, 2, 2, 5);
        run_font(1, FMT_COMPACT, 16, 10, 3, 0, 0);
        add_glyph(32'h7, 2, 2, 5);
        add_glyph(32'h8, 2, 2, 5);
        run_font(2, FMT_COMPACT, 16, 10, 3, 0, 0);
        set_max_glyphs(0);
        add_glyph(32'h7, 2, 2, 5);
        run_font(1, FMT_COMPACT, 16, 10, 3, 0, 0);
        set_max_glyphs(16'hffff);
        add_glyph(32'h7, 2, 2, 5);
        add_glyph(32'h8, 2, 2, 5);
        run_font(32'hffff, FMT_COMPACT, 16, 10, 3, 0, 38);
        add_glyph(32'h7, 2, 2, 5);
        run_font(32'h10000, FMT_LEGACY, 16, 10, 3, 0, 0);

        // random part, one segment per max_glyphs setting
        random_segment(60);
        set_max_glyphs(2);
        random_segment(60);
        set_max_glyphs(1);
        random_segment(60);
        set_max_glyphs(16'($urandom_range(3, 700)));
        random_segment(60);
        set_max_glyphs(bfv_pkg::MAX_GLYPHS_RESET);
        random_segment(60);

        in_valid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge clk);
        $display("covered %0d font files (%0d passing) in %0d bytes, both record layouts,",
                 results, passed, bytes_sent);
        $display("header and metric limits, early ends and %0d max_glyphs settings",
                 settings_used);
        if (mismatches == 0 && pending == 0)
            $display("bitmap_font_file_validator_tb: clean");
        else
            $display("bitmap_font_file_validator_tb: errors");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #5000000;
        $display("bitmap_font_file_validator_tb: errors");
        $finish;
    end

endmodule
